[src/ssti_pkg.sv]
package ssti_pkg;

	typedef struct packed {
		logic [31:0] raw_sample;
		logic        last_sample;
	} in_item_t;

	typedef struct packed {
		logic [31:0] ieee_bits;
		logic [2:0]  status;
		logic        last_out;
	} out_item_t;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_OVER   = 3'd1;
	localparam logic [2:0] ST_UNDER  = 3'd2;
	localparam logic [2:0] ST_ZMANT  = 3'd3;
	localparam logic [2:0] ST_BADFMT = 3'd4;

	localparam logic [3:0] FMT_IBM   = 4'd1;
	localparam logic [3:0] FMT_INT32 = 4'd2;
	localparam logic [3:0] FMT_INT16 = 4'd3;
	localparam logic [3:0] FMT_IEEE  = 4'd5;
	localparam logic [3:0] FMT_INT8  = 4'd8;

	localparam logic       REG_FORMAT = 1'b0;
	localparam logic       REG_SWAP   = 1'b1;

	localparam logic [31:0] MAX_FINITE = 32'h7f7fffff;
	localparam logic [9:0]  IBM_REBIAS = 10'd130;
	localparam logic [9:0]  MAX_EXP    = 10'd254;

	function automatic logic [31:0] rev32(input logic [31:0] x);
		rev32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// index of highest set bit; x must be nonzero
	function automatic logic [4:0] msb_pos(input logic [31:0] x);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (x[i])
				p = 5'(i);
		end
		msb_pos = p;
	endfunction

endpackage

[src/seismic_sample_to_ieee_single.sv]
// Converts SEG-Y trace samples to IEEE-754 single-precision bit patterns.
// Input: pulse start with in_item (raw_sample, last_sample); busy is always
// low, so a sample transfer happens on every cycle that start is high.
// Output: out_item holds ieee_bits, status and last_out for the one cycle
// that out_valid is high; the receiver cannot stall and must take it then.
// The sample is decoded by combinational logic and registered into the
// result register at the transfer edge, so the result is valid in the
// cycle after start. Throughput is one sample per cycle, set by the two
// leading-one searches and rounding adder between input and result register.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 format
// code, 1 byte swap). Write only while no sample is in flight.
// Reset sets format 1 (IBM float), byte swap on, and clears out_valid.
module seismic_sample_to_ieee_single (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ssti_pkg::in_item_t   in_item,
	output logic                 out_valid,
	output ssti_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [3:0]           cfg_data
);
	import ssti_pkg::*;

	logic [3:0]  format_q;
	logic        swap_q;
	logic [31:0] v32;
	logic [15:0] v16;
	logic [7:0]  v8;
	logic        i_neg;
	logic [31:0] i_mag;
	logic [31:0] i_bits;
	logic [31:0] f_bits;
	logic [2:0]  f_st;
	out_item_t   res;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_IBM;
			swap_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORMAT: format_q <= cfg_data;
				REG_SWAP: swap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		v32 = swap_q ? rev32(in_item.raw_sample) : in_item.raw_sample;
		v16 = swap_q ? {in_item.raw_sample[7:0], in_item.raw_sample[15:8]}
			: in_item.raw_sample[15:0];
		v8 = in_item.raw_sample[7:0];
		case (format_q)
			FMT_INT16: begin
				i_neg = v16[15];
				i_mag = {16'd0, v16[15] ? 16'd0 - v16 : v16};
				if (v16 == 16'h8000)
					i_mag = 32'h8000;
			end
			FMT_INT8: begin
				i_neg = v8[7];
				i_mag = {24'd0, v8[7] ? 8'd0 - v8 : v8};
				if (v8 == 8'h80)
					i_mag = 32'h80;
			end
			default: begin
				i_neg = v32[31];
				i_mag = v32[31] ? 32'd0 - v32 : v32;
			end
		endcase
	end

	ssti_int_conv u_int (.neg(i_neg), .mag(i_mag), .bits(i_bits));
	ssti_ibm_conv u_ibm (.w(v32), .bits(f_bits), .st(f_st));

	always_comb begin
		res.last_out = in_item.last_sample;
		res.ieee_bits = 32'd0;
		res.status = ST_OK;
		case (format_q)
			FMT_IBM: begin
				res.ieee_bits = f_bits;
				res.status = f_st;
			end
			FMT_INT32, FMT_INT16, FMT_INT8: res.ieee_bits = i_bits;
			FMT_IEEE: res.ieee_bits = v32;
			default: res.status = ST_BADFMT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= start;
	end

	always_ff @(posedge clk) begin
		if (start)
			out_item <= res;
	end

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> out_valid)
		else $error("result missing after sample transfer");
	a_last_kept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> out_item.last_out == $past(in_item.last_sample))
		else $error("trace end mark lost");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= ST_BADFMT)
		else $error("status code out of range");
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_UNDER || out_item.status == ST_ZMANT
		|| out_item.status == ST_BADFMT) |-> out_item.ieee_bits == 32'd0)
		else $error("flagged result not zero");

endmodule

[src/ssti_int_conv.sv]
module ssti_int_conv (
	input  logic        neg,
	input  logic [31:0] mag,
	output logic [31:0] bits
);
	import ssti_pkg::*;

	logic [4:0]  p;
	logic [4:0]  s;
	logic [31:0] norm;
	logic [31:0] shr;
	logic [31:0] rem;
	logic [31:0] half;
	logic        rnd;
	logic [24:0] m;
	logic [7:0]  e;

	always_comb begin
		p = msb_pos(mag);
		s = (p > 5'd23) ? p - 5'd23 : 5'd0;
		norm = mag << (5'd23 - p);
		shr = mag >> s;
		rem = mag & ((32'd1 << s) - 32'd1);
		half = (s == 5'd0) ? 32'd0 : (32'd1 << (s - 5'd1));
		rnd = (s != 5'd0) && ((rem > half) || ((rem == half) && shr[0]));
		m = (p <= 5'd23) ? norm[24:0] : shr[24:0] + 25'(rnd);
		e = 8'd127 + {3'd0, p};
		if (m[24]) begin
			m = m >> 1;
			e = e + 8'd1;
		end
		bits = (mag == 32'd0) ? 32'd0 : {neg, e, m[22:0]};
	end

endmodule

[src/ssti_ibm_conv.sv]
module ssti_ibm_conv (
	input  logic [31:0] w,
	output logic [31:0] bits,
	output logic [2:0]  st
);
	import ssti_pkg::*;

	logic [23:0] mant;
	logic [4:0]  p;
	logic [4:0]  lz;
	logic [9:0]  t;
	logic [23:0] nm;

	always_comb begin
		mant = w[23:0];
		p = msb_pos({8'd0, mant});
		lz = 5'd23 - p;
		nm = mant << lz;
		t = {1'b0, w[30:24], 2'b00} - IBM_REBIAS - {5'd0, lz};
		bits = 32'd0;
		st = ST_OK;
		if (w == 32'd0) begin
			st = ST_OK;
		end else if (mant == 24'd0) begin
			st = ST_ZMANT;
		end else if (!t[9] && t > MAX_EXP) begin
			st = ST_OVER;
			bits = {w[31], MAX_FINITE[30:0]};
		end else if (t[9] || t == 10'd0) begin
			st = ST_UNDER;
		end else begin
			bits = {w[31], t[7:0], nm[22:0]};
		end
	end

endmodule
